// ===== rtl/pstm_pkg.sv =====
package pstm_pkg;

  localparam int WORD_W         = 32;
  localparam int IDX_W          = 29;
  localparam int DEG_W          = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int LANES          = 8;
  localparam int LANE_W         = 3;
  localparam int NUM_COEFS      = 7;
  localparam int MAX_DEGREE_DEF = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [LANES-1:0] lane_words_t;
  typedef word_t [NUM_COEFS-1:0] coef_arr_t;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE = 4'd0,
    REG_COEF_0 = 4'd1,
    REG_COEF_1 = 4'd2,
    REG_COEF_2 = 4'd3,
    REG_COEF_3 = 4'd4,
    REG_COEF_4 = 4'd5,
    REG_COEF_5 = 4'd6,
    REG_COEF_6 = 4'd7
  } cfg_reg_t;

  // One pipeline slot: eight sample positions and their Horner accumulators.
  typedef struct packed {
    logic        valid;
    logic        last;
    lane_words_t x;
    lane_words_t acc;
  } pipe_t;

endpackage

// ===== rtl/pstm_cfg_regs.sv =====
module pstm_cfg_regs #(
  parameter int MAX_DEGREE = pstm_pkg::MAX_DEGREE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pstm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  pstm_pkg::word_t                cfg_data,
  output pstm_pkg::coef_arr_t            coef_eff
);

  localparam logic [pstm_pkg::DEG_W-1:0] MaxDeg = pstm_pkg::DEG_W'(MAX_DEGREE);
  // Only coef_1 is set after reset, so the polynomial starts as p(x) = x.
  localparam pstm_pkg::coef_arr_t CoefRst = pstm_pkg::coef_arr_t'(1) << pstm_pkg::WORD_W;

  logic [pstm_pkg::DEG_W-1:0] degree_r;
  logic [pstm_pkg::DEG_W-1:0] deg_eff;
  pstm_pkg::coef_arr_t        coef_r;
  logic                       wr_en;
  logic [pstm_pkg::LANE_W-1:0] coef_sel;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;
  assign coef_sel  = pstm_pkg::LANE_W'(cfg_index - pstm_pkg::REG_COEF_0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= pstm_pkg::DEG_W'(1);
      coef_r   <= CoefRst;
    end else if (wr_en) begin
      case (cfg_index) inside
        pstm_pkg::REG_DEGREE: begin
          degree_r <= cfg_data[pstm_pkg::DEG_W-1:0];
        end
        [pstm_pkg::REG_COEF_0:pstm_pkg::REG_COEF_6]: begin
          coef_r[coef_sel] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Coefficients above the active degree read as zero, so a fixed-depth
  // Horner chain gives the same value as a shorter one.
  assign deg_eff = (degree_r > MaxDeg) ? MaxDeg : degree_r;

  always_comb begin
    for (int k = 0; k < pstm_pkg::NUM_COEFS; k++) begin
      coef_eff[k] = (pstm_pkg::DEG_W'(k) <= deg_eff) ? coef_r[k] : '0;
    end
  end

endmodule

// ===== rtl/pstm_horner_stage.sv =====
module pstm_horner_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  pstm_pkg::word_t coef,
  input  pstm_pkg::pipe_t d,
  output pstm_pkg::pipe_t q
);

  pstm_pkg::lane_words_t acc_nxt;
  pstm_pkg::pipe_t       q_r;

  // One Horner step per lane, all arithmetic modulo 2^32.
  always_comb begin
    for (int j = 0; j < pstm_pkg::LANES; j++) begin
      acc_nxt[j] = d.x[j] * d.acc[j] + coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= d.valid;
    end
    q_r.last <= d.last;
    q_r.x    <= d.x;
    q_r.acc  <= acc_nxt;
  end

  assign q = q_r;

endmodule

// ===== rtl/pstm_parity_out.sv =====
module pstm_parity_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pstm_pkg::pipe_t               d,
  output logic                          out_strobe,
  output logic [pstm_pkg::LANES-1:0]    out_seq_byte,
  output logic                          out_last_out
);

  logic                       strobe_r;
  logic [pstm_pkg::LANES-1:0] byte_r;
  logic [pstm_pkg::LANES-1:0] byte_nxt;
  logic                       last_r;

  // First sample position lands in the most significant bit.
  always_comb begin
    for (int j = 0; j < pstm_pkg::LANES; j++) begin
      byte_nxt[pstm_pkg::LANES-1-j] = ^d.acc[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= d.last;
  end

  assign out_strobe   = strobe_r;
  assign out_seq_byte = byte_r;
  assign out_last_out = last_r;

endmodule

// ===== rtl/polynomial_sampled_thue_morse_bytes.sv =====
// Thue-Morse bytes sampled along a programmable polynomial. Each accepted
// byte index n yields one byte whose bit 7-j is the parity of p(8n+j), with
// p evaluated modulo 2^32 from the degree and coefficient registers. A new
// index is taken every clock cycle while busy is low, and each result
// passes through one input register, one multiply-add stage per
// remaining Horner step, and one parity register. The result strobe
// lasts a single cycle and cannot be held off, so the receiver must take
// every result when it shows. Busy is high only while reset is applied
// and in the cycle after it. Configuration writes must happen while no
// transfer is in flight.
module polynomial_sampled_thue_morse_bytes #(
  parameter int MAX_DEGREE = pstm_pkg::MAX_DEGREE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pstm_pkg::IDX_W-1:0]     in_byte_index,
  input  logic                           in_last_in,
  output logic                           out_strobe,
  output logic [pstm_pkg::LANES-1:0]     out_seq_byte,
  output logic                           out_last_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pstm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pstm_pkg::WORD_W-1:0]    cfg_data
);

  logic                busy_r;
  logic                accept;
  pstm_pkg::coef_arr_t coef_eff;
  pstm_pkg::pipe_t     stg [MAX_DEGREE+1];
  pstm_pkg::pipe_t     in_r;

  // The block never back-pressures after reset; busy only covers reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  pstm_cfg_regs #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_eff  (coef_eff)
  );

  // Input stage. The eight sample positions share the upper bits of 8n and
  // differ only in the low three bits, so no adder is needed. The
  // accumulators start at the top coefficient, which is the first Horner
  // step with a zero accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
    end else begin
      in_r.valid <= accept;
    end
    in_r.last <= in_last_in;
    for (int j = 0; j < pstm_pkg::LANES; j++) begin
      in_r.x[j]   <= {in_byte_index, pstm_pkg::LANE_W'(j)};
      in_r.acc[j] <= coef_eff[MAX_DEGREE];
    end
  end

  assign stg[0] = in_r;

  // One multiply-add stage per remaining coefficient, highest first.
  for (genvar s = 1; s <= MAX_DEGREE; s++) begin : g_horner
    pstm_horner_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .coef  (coef_eff[MAX_DEGREE-s]),
      .d     (stg[s-1]),
      .q     (stg[s])
    );
  end

  pstm_parity_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .d            (stg[MAX_DEGREE]),
    .out_strobe   (out_strobe),
    .out_seq_byte (out_seq_byte),
    .out_last_out (out_last_out)
  );

endmodule

// ===== rtl/pstm_checker.sv =====
module pstm_checker #(
  parameter int MAX_DEGREE = pstm_pkg::MAX_DEGREE_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_in,
  input logic out_strobe,
  input logic out_last_out
);

  localparam int Lat = MAX_DEGREE + 2;

  logic accept;

  assign accept = start && !busy;

  // Every transfer gives a result after the fixed pipeline latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##Lat out_strobe)
    else $error("no result after an accepted transfer");

  // No result appears without a transfer that caused it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##Lat !out_strobe)
    else $error("result without a matching transfer");

  // The last flag travels with its own item.
  a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##Lat (out_last_out == $past(in_last_in, Lat)))
    else $error("last flag does not match its transfer");

endmodule

bind polynomial_sampled_thue_morse_bytes pstm_checker #(
  .MAX_DEGREE (MAX_DEGREE)
) u_pstm_checker (.*);
